// ===== design/flph_pkg.sv =====
package flph_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_HIT       = 3'd2,
      ST_MISS      = 3'd3,
      ST_FULL      = 3'd4,
      ST_TOO_LONG  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_COLLECT,
      S_MOD,
      S_CLEAR,
      S_RD_SLOT,
      S_WAIT_SLOT,
      S_CHECK_SLOT,
      S_RD_BYTE,
      S_WAIT_BYTE,
      S_CHECK_BYTE,
      S_WR_BYTES,
      S_RESULT
   } fsm_type;

   localparam logic REQ_INSERT = 1'b0;

endpackage

// ===== design/flph_ram.sv =====
module flph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/flph_hash.sv =====
// FNV-1a byte fold: one multiply per beat.
module flph_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        clear,
   input  logic [7:0]  data_byte,
   output logic [31:0] hash
);

   logic [31:0] hash_ff, hash_in;

   always_comb begin
      hash_in = hash_ff;
      if (step) begin
         hash_in = (hash_ff ^ {24'd0, data_byte}) * flph_pkg::FNV_PRIME;
      end else if (clear) begin
         hash_in = flph_pkg::FNV_BASIS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= flph_pkg::FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ===== design/fnv1a_linear_probe_hash_table.sv =====
// Key bytes are taken one beat per cycle while hashing; on the last byte,
// the hash modulo runs bit-serially in S_MOD, each probe steps through
// S_RD_SLOT, S_WAIT_SLOT, S_CHECK_SLOT, then S_WAIT_BYTE, S_CHECK_BYTE per
// compared key byte, and an insert writes its key bytes one per cycle, then
// S_RESULT offers the beat; throughput is data dependent at key end.
// Reset: synchronous; S_CLEAR clears TABLE_ENTRIES used flags, no beat taken.
module fnv1a_linear_probe_hash_table #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: key_byte[7:0], entry_value[39:8]; tuser: req_type; tlast: key_last
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   // tdata: status[2:0], value_out[34:3], slot_index[44:35], key_hash[76:45]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   localparam int SW = $clog2(TABLE_ENTRIES);
   localparam int KW = $clog2(MAX_KEY_BYTES) > 0 ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LW = $clog2(MAX_KEY_BYTES + 1);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int BW = SW + KW;

   flph_pkg::fsm_type state_ff, state_in;

   logic [10:0]        size_cfg_ff;
   logic [CW-1:0]      size_eff;
   logic [LW-1:0]      len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic               req_type_ff, req_type_in;
   logic [31:0]        val_ff, val_in;
   logic [31:0]        hash_ff, hash_in;
   // restoring divider for hash modulo size
   logic [CW:0]        rem_ff, rem_in;
   logic [5:0]         bit_ff, bit_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      probes_ff, probes_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic [2:0]         status_ff, status_in;
   logic [31:0]        vout_ff, vout_in;
   logic [SW-1:0]      slot_out_ff, slot_out_in;
   logic               out_valid_ff, out_valid_in;

   logic               beat_in, beat_out;
   logic [31:0]        hash_now;

   // memories
   logic               used_we, used_rd;
   logic [SW-1:0]      used_wa;
   logic               used_wd;
   logic [LW+32-1:0]   meta_rd, meta_wd;
   logic               meta_we;
   logic               key_we;
   logic [KW-1:0]      key_wa, key_ra;
   logic [7:0]         key_rd;
   logic               slot_we;
   logic [BW-1:0]      slot_wa, slot_ra;
   logic [7:0]         slot_rd;

   assign beat_in  = req_tvalid & req_tready;
   assign beat_out = rsp_tvalid & rsp_tready;
   assign req_tready = (state_ff == flph_pkg::S_COLLECT);

   always_comb begin
      if (size_cfg_ff == 11'd0) begin
         size_eff = CW'(1);
      end else if ({21'd0, size_cfg_ff} > 32'(TABLE_ENTRIES)) begin
         size_eff = CW'(TABLE_ENTRIES);
      end else begin
         size_eff = CW'(size_cfg_ff);
      end
   end

   // restart the running hash once the key has been taken
   flph_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .step      (beat_in),
      .clear     (state_ff == flph_pkg::S_RESULT),
      .data_byte (req_tdata[7:0]),
      .hash      (hash_now)
   );

   // buffered key
   assign key_we = beat_in && (len_ff < LW'(MAX_KEY_BYTES));
   assign key_wa = KW'(len_ff);
   assign key_ra = KW'(pos_in);

   flph_ram #(.WIDTH(8), .DEPTH(1 << KW)) u_key_buf (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(req_tdata[7:0]),
      .rd_addr(key_ra), .rd_data(key_rd)
   );

   flph_ram #(.WIDTH(1), .DEPTH(1 << SW)) u_used (
      .clock(clock), .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
      .rd_addr(idx_in), .rd_data(used_rd)
   );

   // slot length and value
   flph_ram #(.WIDTH(LW + 32), .DEPTH(1 << SW)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(idx_ff), .wr_data(meta_wd),
      .rd_addr(idx_in), .rd_data(meta_rd)
   );

   flph_ram #(.WIDTH(8), .DEPTH(1 << BW)) u_slot_key (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(key_rd),
      .rd_addr(slot_ra), .rd_data(slot_rd)
   );

   assign meta_wd = {len_ff, val_ff};
   assign slot_ra = {idx_ff, KW'(pos_in)};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         flph_pkg::S_CLEAR: begin
            if (idx_ff == SW'(TABLE_ENTRIES - 1)) state_in = flph_pkg::S_COLLECT;
         end
         flph_pkg::S_COLLECT: begin
            if (beat_in && req_tlast) begin
               if (ovf_ff || len_ff >= LW'(MAX_KEY_BYTES)) begin
                  state_in = flph_pkg::S_RESULT;
               end else begin
                  state_in = flph_pkg::S_MOD;
               end
            end
         end
         flph_pkg::S_MOD: if (bit_ff == 6'd0) state_in = flph_pkg::S_RD_SLOT;
         flph_pkg::S_RD_SLOT: state_in = flph_pkg::S_WAIT_SLOT;
         flph_pkg::S_WAIT_SLOT: state_in = flph_pkg::S_CHECK_SLOT;
         flph_pkg::S_CHECK_SLOT: begin
            if (!used_rd) begin
               state_in = (req_type_ff == flph_pkg::REQ_INSERT) ? flph_pkg::S_WR_BYTES
                                                                : flph_pkg::S_RESULT;
            end else if (meta_rd[LW+31:32] == len_ff) begin
               state_in = (len_ff == '0) ? flph_pkg::S_RESULT : flph_pkg::S_WAIT_BYTE;
            end else if (probes_ff + CW'(1) == size_eff) begin
               state_in = flph_pkg::S_RESULT;
            end else begin
               state_in = flph_pkg::S_RD_SLOT;
            end
         end
         flph_pkg::S_WAIT_BYTE: state_in = flph_pkg::S_CHECK_BYTE;
         flph_pkg::S_CHECK_BYTE: begin
            if (slot_rd != key_rd) begin
               state_in = (probes_ff + CW'(1) == size_eff) ? flph_pkg::S_RESULT
                                                           : flph_pkg::S_RD_SLOT;
            end else if (pos_ff + LW'(1) == len_ff) begin
               state_in = flph_pkg::S_RESULT;
            end else begin
               state_in = flph_pkg::S_WAIT_BYTE;
            end
         end
         flph_pkg::S_WR_BYTES: begin
            if (pos_ff + LW'(1) >= len_ff) state_in = flph_pkg::S_RESULT;
         end
         flph_pkg::S_RESULT: begin
            if (!out_valid_ff || beat_out) state_in = flph_pkg::S_COLLECT;
         end
         default: state_in = flph_pkg::S_COLLECT;
      endcase
   end

   // datapath and outputs
   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      req_type_in  = req_type_ff;
      val_in       = val_ff;
      hash_in      = hash_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      vout_in      = vout_ff;
      slot_out_in  = slot_out_ff;
      out_valid_in = out_valid_ff & ~beat_out;
      used_we      = 1'b0;
      used_wa      = idx_ff;
      used_wd      = 1'b1;
      meta_we      = 1'b0;
      slot_we      = 1'b0;
      slot_wa      = {idx_ff, KW'(pos_ff)};
      case (state_ff)
         flph_pkg::S_CLEAR: begin
            used_we = 1'b1;
            used_wd = 1'b0;
            idx_in  = idx_ff + SW'(1);
         end
         flph_pkg::S_COLLECT: begin
            pos_in = '0;
            if (beat_in) begin
               if (len_ff < LW'(MAX_KEY_BYTES)) len_in = len_ff + LW'(1);
               else ovf_in = 1'b1;
               if (req_tlast) begin
                  hash_in     = (hash_now ^ {24'd0, req_tdata[7:0]})
                                * flph_pkg::FNV_PRIME;
                  req_type_in = req_tuser;
                  val_in      = req_tdata[39:8];
                  rem_in      = '0;
                  bit_in      = 6'd32;
                  probes_in   = '0;
                  vout_in     = '0;
                  slot_out_in = '0;
                  status_in   = (ovf_ff || len_ff >= LW'(MAX_KEY_BYTES))
                                ? flph_pkg::ST_TOO_LONG : flph_pkg::ST_FULL;
               end
            end
         end
         flph_pkg::S_MOD: begin
            if (bit_ff != 6'd0) begin
               rem_in = {rem_ff[CW-1:0], hash_ff[bit_ff[4:0] - 5'd1]};
               if (rem_in >= {1'b0, size_eff}) rem_in = rem_in - {1'b0, size_eff};
               bit_in = bit_ff - 6'd1;
            end else begin
               idx_in = SW'(rem_ff);
            end
         end
         flph_pkg::S_CHECK_SLOT: begin
            pos_in = '0;
            if (!used_rd) begin
               if (req_type_ff == flph_pkg::REQ_INSERT) begin
                  used_we     = 1'b1;
                  meta_we     = 1'b1;
                  status_in   = flph_pkg::ST_INSERTED;
                  slot_out_in = idx_ff;
               end else begin
                  status_in = flph_pkg::ST_MISS;
               end
            end else if (meta_rd[LW+31:32] == len_ff) begin
               if (len_ff == '0) begin
                  status_in   = req_type_ff ? flph_pkg::ST_HIT : flph_pkg::ST_DUPLICATE;
                  vout_in     = req_type_ff ? meta_rd[31:0] : 32'd0;
                  slot_out_in = idx_ff;
               end else begin
                  vout_in = meta_rd[31:0];
               end
            end else begin
               probes_in = probes_ff + CW'(1);
               idx_in = (CW'(idx_ff) + CW'(1) == size_eff) ? '0 : idx_ff + SW'(1);
            end
         end
         flph_pkg::S_CHECK_BYTE: begin
            if (slot_rd != key_rd) begin
               pos_in    = '0;
               vout_in   = '0;
               probes_in = probes_ff + CW'(1);
               idx_in = (CW'(idx_ff) + CW'(1) == size_eff) ? '0 : idx_ff + SW'(1);
            end else if (pos_ff + LW'(1) == len_ff) begin
               status_in   = req_type_ff ? flph_pkg::ST_HIT : flph_pkg::ST_DUPLICATE;
               if (!req_type_ff) vout_in = '0;
               slot_out_in = idx_ff;
            end else begin
               pos_in = pos_ff + LW'(1);
            end
         end
         flph_pkg::S_WR_BYTES: begin
            slot_we = (len_ff != '0);
            pos_in  = pos_ff + LW'(1);
         end
         flph_pkg::S_RESULT: begin
            if (!out_valid_ff || beat_out) begin
               out_valid_in = 1'b1;
               len_in       = '0;
               ovf_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // hold the result beat until taken
   logic [79:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (state_ff == flph_pkg::S_RESULT && (!out_valid_ff || beat_out)) begin
         rsp_data_ff <= {3'd0, hash_ff, 10'(slot_out_ff), vout_ff, status_ff};
      end
   end
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flph_pkg::S_CLEAR;
         size_cfg_ff  <= 11'd256;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) size_cfg_ff <= csr_wr_data;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      val_ff      <= val_in;
      hash_ff     <= hash_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      probes_ff   <= probes_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      vout_ff     <= vout_in;
      slot_out_ff <= slot_out_in;
   end

endmodule

// ===== dv/flph_checker.sv =====
module flph_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   output int          fail_count,
   output int          pending,
   output int          results_seen,
   output int          status_seen [6]
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 1024;
   localparam int KEY_MAX = 32;

   typedef struct packed {
      flph_pkg::status_type status;
      logic [31:0]          value;
      logic [9:0]           slot;
      logic [31:0]          hash;
   } lookup_result_type;

   lookup_result_type result_fifo [$];

   // shadow of the table
   logic [31:0] run_hash;
   logic [7:0]  key_bytes [KEY_MAX];
   int          key_len;
   logic        key_long;
   logic        used      [SLOTS];
   int          used_len  [SLOTS];
   logic [7:0]  used_key  [SLOTS][KEY_MAX];
   logic [31:0] used_val  [SLOTS];
   logic [10:0] table_size;

   assign pending = result_fifo.size();

   function automatic lookup_result_type probe_table(input logic is_lookup,
                                                     input logic [31:0] val);
      lookup_result_type r;
      int unsigned size;
      int unsigned idx;
      logic done;
      logic same;
      r.status = flph_pkg::ST_FULL;
      r.value  = '0;
      r.slot   = '0;
      r.hash   = run_hash;
      if (key_long) begin
         r.status = flph_pkg::ST_TOO_LONG;
         return r;
      end
      size = (table_size == 0) ? 1 : (table_size > SLOTS) ? SLOTS : table_size;
      idx  = run_hash % size;
      done = 1'b0;
      for (int n = 0; n < size && !done; n++) begin
         if (!used[idx]) begin
            if (!is_lookup) begin
               used[idx] = 1'b1;
               used_len[idx] = key_len;
               for (int i = 0; i < key_len; i++) used_key[idx][i] = key_bytes[i];
               used_val[idx] = val;
               r.status = flph_pkg::ST_INSERTED;
               r.slot = idx[9:0];
            end else begin
               r.status = flph_pkg::ST_MISS;
            end
            done = 1'b1;
         end else begin
            same = (used_len[idx] == key_len);
            for (int i = 0; i < key_len; i++)
               if (used_key[idx][i] != key_bytes[i]) same = 1'b0;
            if (same) begin
               if (is_lookup) begin
                  r.status = flph_pkg::ST_HIT;
                  r.value = used_val[idx];
               end else begin
                  r.status = flph_pkg::ST_DUPLICATE;
               end
               r.slot = idx[9:0];
               done = 1'b1;
            end else begin
               idx = (idx + 1 == size) ? 0 : idx + 1;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         run_hash = flph_pkg::FNV_BASIS;
         key_len = 0;
         key_long = 1'b0;
         table_size = 11'd256;
         for (int s = 0; s < SLOTS; s++) used[s] = 1'b0;
         result_fifo.delete();
         fail_count <= 0;
         results_seen <= 0;
         for (int k = 0; k < 6; k++) status_seen[k] <= 0;
      end else begin
         if (csr_wr_en) table_size = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.status = flph_pkg::status_type'(rsp_tdata[2:0]);
            got.value  = rsp_tdata[34:3];
            got.slot   = rsp_tdata[44:35];
            got.hash   = rsp_tdata[76:45];
            results_seen <= results_seen + 1;
            if (rsp_tdata[2:0] < 6) status_seen[rsp_tdata[2:0]] <= status_seen[rsp_tdata[2:0]] + 1;
            if (result_fifo.size() == 0) begin
               $display("%0t: unexpected result beat %h", $realtime, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = result_fifo.pop_front();
               if (got.status !== want.status || got.value !== want.value ||
                   got.slot !== want.slot || got.hash !== want.hash ||
                   rsp_tdata[79:77] !== 3'b0) begin
                  $display("%0t: mismatch status exp %0d act %0d, value exp %h act %h",
                           $realtime, want.status, got.status, want.value, got.value);
                  $display("%0t:          slot exp %0d act %0d, hash exp %h act %h",
                           $realtime, want.slot, got.slot, want.hash, got.hash);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            run_hash = (run_hash ^ {24'd0, req_tdata[7:0]}) * flph_pkg::FNV_PRIME;
            if (key_len < KEY_MAX) begin
               key_bytes[key_len] = req_tdata[7:0];
               key_len++;
            end else begin
               key_long = 1'b1;
            end
            if (req_tlast) begin
               result_fifo.push_back(probe_table(req_tuser, req_tdata[39:8]));
               run_hash = flph_pkg::FNV_BASIS;
               key_len = 0;
               key_long = 1'b0;
            end
         end
      end
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic REQ_INS = 1'b0;
   localparam logic REQ_LOOK = 1'b1;
   localparam int POOL_KEYS = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // key_byte[7:0], entry_value[39:8]
   logic        req_tuser = 1'b0; // req_type
   logic        req_tlast = 1'b0; // key_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // status, value_out, slot_index, key_hash
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0;

   int fail_count;
   int pending;
   int results_seen;
   int status_seen [6];

   // key pool: reused so that duplicates, hits and collisions happen often
   logic [7:0] pool_bytes [POOL_KEYS][32];
   int         pool_len   [POOL_KEYS];
   int         beats_sent;
   int         keys_sent;
   int         sizes_used;
   logic       req_burst;
   logic       rsp_burst;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fnv1a_linear_probe_hash_table u_top (.*);

   flph_checker u_checker (.*);

   // Response side: stall at random before each beat, with bursts of none.
   initial begin
      int gap;
      int count;
      count = 0;
      rsp_burst = 1'b0;
      forever begin
         @(negedge clock);
         gap = rsp_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         // tvalid only moves at rising edges, so the value seen at
         // the falling edge is what the next rising edge samples
         while (!rsp_tvalid) @(negedge clock);
         @(posedge clock);
         count++;
         if (count % 40 == 0) rsp_burst = ~rsp_burst;
      end
   end

   // Drive one beat: maybe idle first (never in a burst), then hold until the handshake lands.
   task automatic push_beat(input logic req, input logic [7:0] kb, input logic last,
                            input logic [31:0] val);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {val, kb};
      req_tuser  = req;
      req_tlast  = last;
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      beats_sent++;
   endtask

   // Send a whole key; type and value on the non-final beats are scrambled
   // because only the last beat counts. pool index below zero: fresh bytes.
   task automatic send_key(input logic req, input int pidx, input int len,
                           input logic [31:0] val);
      logic [7:0] kb;
      for (int i = 0; i < len; i++) begin
         kb = (pidx >= 0) ? pool_bytes[pidx][i] : 8'($urandom_range(0, 255));
         if (i == len - 1) push_beat(req, kb, 1'b1, val);
         else push_beat(1'($urandom_range(0, 1)), kb, 1'b0, $urandom);
      end
      keys_sent++;
   endtask

   task automatic send_short(input logic req, input logic [7:0] b0, input logic [31:0] val);
      push_beat(req, b0, 1'b1, val);
      keys_sent++;
   endtask

   // Retune the table only once the block has drained.
   task automatic set_size(input logic [10:0] size);
      wait (pending == 0);
      repeat (10) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = size;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sizes_used++;
   endtask

   initial begin
      logic [10:0] plan [10];
      int r;
      int pidx;
      int phase_end;
      plan = '{11'd2047, 11'd1024, 11'd3, 11'd5, 11'd17, 11'd0, 11'd1, 11'd300,
               11'd64, 11'd1024};
      beats_sent = 0;
      keys_sent = 0;
      sizes_used = 0;
      req_burst = 1'b0;
      for (int k = 0; k < POOL_KEYS; k++) begin
         pool_len[k] = (k % 8 == 7) ? 32 : $urandom_range(1, 6);
         for (int i = 0; i < 32; i++) pool_bytes[k][i] = 8'($urandom_range(0, 255));
      end
      pool_bytes[0][0] = 8'h00;
      pool_bytes[1][0] = 8'hFF;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default size, value extremes, hit, miss, duplicate
      send_short(REQ_INS, 8'h00, 32'h8000_0000);
      send_short(REQ_INS, 8'hFF, 32'h7FFF_FFFF);
      send_short(REQ_LOOK, 8'h00, 32'h0);
      send_short(REQ_LOOK, 8'hFF, 32'h0);
      send_short(REQ_INS, 8'h00, 32'h1234_5678);
      send_key(REQ_LOOK, -1, 2, 32'h0);
      send_short(REQ_LOOK, 8'h5A, 32'h0);
      // one slot: second key finds the table full, for insert and lookup
      set_size(11'd1);
      send_short(REQ_INS, 8'h11, 32'hFFFF_FFFF);
      send_short(REQ_INS, 8'h22, 32'h0000_0001);
      send_short(REQ_LOOK, 8'h22, 32'h0);
      send_short(REQ_LOOK, 8'h11, 32'h0);
      // zero acts as one slot
      set_size(11'd0);
      send_short(REQ_LOOK, 8'h11, 32'h0);
      send_short(REQ_INS, 8'h33, 32'h0);

      // random phases over a spread of table sizes
      for (int p = 0; p < 10; p++) begin
         set_size(plan[p]);
         req_burst = (p % 3 == 2);
         phase_end = beats_sent + 90;
         while (beats_sent < phase_end) begin
            r = $urandom_range(0, 99);
            pidx = $urandom_range(0, POOL_KEYS - 1);
            if (r < 45) send_key(REQ_INS, pidx, pool_len[pidx], $urandom);
            else if (r < 88) send_key(REQ_LOOK, pidx, pool_len[pidx], $urandom);
            else if (r < 96) send_key(1'($urandom_range(0, 1)), -1, $urandom_range(1, 6),
                                      $urandom);
            else send_key(1'($urandom_range(0, 1)), -1, $urandom_range(33, 40), $urandom);
         end
      end

      wait (pending == 0);
      repeat (50) @(posedge clock);
      $display("Covered %0d keys in %0d beats across %0d table size writes.",
               keys_sent, beats_sent, sizes_used);
      $display("Results: %0d ins, %0d dup, %0d hit, %0d miss, %0d full, %0d too long.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5]);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
